>>> rtl/core/gls_pkg.sv
// Shared types, field widths and codes for the grid line-of-sight walk.
package gls_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int COORD_W     = 8;
    localparam int CELL_W      = 6;
    localparam int KIND_W      = 2;
    localparam int LIM_W       = 9;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 8'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOLID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEST  = 2'd2;

    localparam logic [1:0] VERDICT_CLEAR = 2'd0;
    localparam logic [1:0] VERDICT_DEST  = 2'd1;
    localparam logic [1:0] VERDICT_SOLID = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_col;
        logic signed [COORD_W-1:0] from_row;
        logic signed [COORD_W-1:0] to_col;
        logic signed [COORD_W-1:0] to_row;
    } t_query;

    typedef struct packed {
        logic [LIM_W-1:0] rows;
        logic [LIM_W-1:0] cols;
    } t_limits;

    typedef struct packed {
        logic                      blocked_found;
        logic [1:0]                verdict;
        logic signed [COORD_W-1:0] blocked_col;
        logic signed [COORD_W-1:0] blocked_row;
    } t_result;

endpackage

>>> rtl/core/gls_grid_mem.sv
// Grid cell store: one write port and one registered read port.
module gls_grid_mem #(
    parameter int AW = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [gls_pkg::KIND_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [gls_pkg::KIND_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [gls_pkg::KIND_W-1:0] r_mem [DEPTH];
    logic [gls_pkg::KIND_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gls_walker.sv
// Bresenham line stepper that steps one grid cell per cycle, reads the cells inside the grid and grades the line.
module gls_walker #(
    parameter int MAX_ROWS = gls_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gls_pkg::DEF_MAX_COLS,
    parameter int AW       = $clog2(MAX_ROWS) + $clog2(MAX_COLS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  gls_pkg::t_query            i_query,
    input  gls_pkg::t_limits           i_lim,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [gls_pkg::KIND_W-1:0] i_rd_data,
    output logic                       o_idle,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output gls_pkg::t_result           o_res
);

    localparam int RB = $clog2(MAX_ROWS);
    localparam int CB = $clog2(MAX_COLS);

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_WALK = 3'b010,
        W_DONE = 3'b100
    } t_wstate;

    t_wstate r_state;

    logic signed [7:0]  r_x, r_y, r_x1, r_y1;
    logic [7:0]         r_dx, r_dy;
    logic               r_sxn, r_syn;
    logic signed [10:0] r_err;
    logic               r_issue_done;
    logic               r_pv, r_pin, r_plast;
    logic signed [7:0]  r_px, r_py;
    logic [1:0]         r_verdict;
    logic               r_found;
    logic signed [7:0]  r_bc, r_br;

    logic signed [8:0]  dxs, dys;
    logic [8:0]         dxa, dya;
    logic signed [10:0] err0;
    logic [8:0]         x9, y9;
    logic               cur_in, cur_end, issue;
    logic signed [11:0] e2, neg_dy, pos_dx;
    logic               step_x, step_y;
    logic signed [10:0] dx11, dy11, n_err;
    logic signed [7:0]  n_x, n_y;
    logic               blk, solid;

    always_comb begin
        dxs  = $signed({i_query.to_col[7], i_query.to_col})
             - $signed({i_query.from_col[7], i_query.from_col});
        dys  = $signed({i_query.to_row[7], i_query.to_row})
             - $signed({i_query.from_row[7], i_query.from_row});
        dxa  = dxs[8] ? 9'(-dxs) : 9'(dxs);
        dya  = dys[8] ? 9'(-dys) : 9'(dys);
        err0 = $signed({3'b000, dxa[7:0]}) - $signed({3'b000, dya[7:0]});

        x9      = {1'b0, r_x};
        y9      = {1'b0, r_y};
        cur_in  = !r_x[7] && !r_y[7] && (y9 < i_lim.rows) && (x9 < i_lim.cols);
        cur_end = (r_x == r_x1) && (r_y == r_y1);
        issue   = (r_state == W_WALK) && !r_issue_done;

        dx11   = $signed({3'b000, r_dx});
        dy11   = $signed({3'b000, r_dy});
        e2     = {r_err, 1'b0};
        neg_dy = -$signed({4'b0000, r_dy});
        pos_dx = $signed({4'b0000, r_dx});
        step_x = e2 > neg_dy;
        step_y = e2 < pos_dx;
        n_err  = r_err - (step_x ? dy11 : 11'sd0) + (step_y ? dx11 : 11'sd0);
        n_x    = step_x ? (r_sxn ? r_x - 8'sd1 : r_x + 8'sd1) : r_x;
        n_y    = step_y ? (r_syn ? r_y - 8'sd1 : r_y + 8'sd1) : r_y;

        blk   = r_pv && r_pin && ((i_rd_data == gls_pkg::KIND_SOLID)
                                  || (i_rd_data == gls_pkg::KIND_DEST));
        solid = blk && (i_rd_data == gls_pkg::KIND_SOLID);
    end

    assign o_rd_en   = issue && cur_in;
    assign o_rd_addr = {y9[RB-1:0], x9[CB-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= W_IDLE;
            r_pv         <= 1'b0;
            r_issue_done <= 1'b0;
            r_found      <= 1'b0;
            r_verdict    <= gls_pkg::VERDICT_CLEAR;
        end else begin
            unique case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        r_x          <= i_query.from_col;
                        r_y          <= i_query.from_row;
                        r_x1         <= i_query.to_col;
                        r_y1         <= i_query.to_row;
                        r_dx         <= dxa[7:0];
                        r_dy         <= dya[7:0];
                        r_sxn        <= !(i_query.from_col < i_query.to_col);
                        r_syn        <= !(i_query.from_row < i_query.to_row);
                        r_err        <= err0;
                        r_bc         <= i_query.to_col;
                        r_br         <= i_query.to_row;
                        r_pv         <= 1'b0;
                        r_issue_done <= 1'b0;
                        r_found      <= 1'b0;
                        r_verdict    <= gls_pkg::VERDICT_CLEAR;
                        r_state      <= W_WALK;
                    end
                end
                W_WALK: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_px    <= r_x;
                        r_py    <= r_y;
                        r_pin   <= cur_in;
                        r_plast <= cur_end;
                        if (cur_end) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_x   <= n_x;
                            r_y   <= n_y;
                            r_err <= n_err;
                        end
                    end
                    if (blk && !r_found) begin
                        r_found <= 1'b1;
                        r_bc    <= r_px;
                        r_br    <= r_py;
                    end
                    if (solid) begin
                        r_verdict <= gls_pkg::VERDICT_SOLID;
                        r_state   <= W_DONE;
                    end else begin
                        if (blk) begin
                            r_verdict <= gls_pkg::VERDICT_DEST;
                        end
                        if (r_pv && r_plast) begin
                            r_state <= W_DONE;
                        end
                    end
                end
                W_DONE: begin
                    if (i_res_ready) begin
                        r_state <= W_IDLE;
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == W_IDLE);
    assign o_res_valid = (r_state == W_DONE);

    always_comb begin
        o_res.verdict       = r_verdict;
        o_res.blocked_found = r_found;
        o_res.blocked_col   = r_bc;
        o_res.blocked_row   = r_br;
    end

endmodule

>>> rtl/core/grid_line_of_sight_walk.sv
// Grid line-of-sight walk: a cell store that takes cell writes and answers line queries.
//
// After reset the block clears the grid store, one cell per cycle, over all
// 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) cells (4096 at the default size);
// it accepts no input beat until that pass ends, while configuration writes
// are taken at any time. During a query the walker steps one cell per cycle
// along the line, reading each cell inside the grid; the store returns the
// data in the cycle after the read, and a solid cell ends the walk early.
// One item is in work at a time, and a finished result waits in the output
// register while the next item is taken.
module grid_line_of_sight_walk #(
    parameter int MAX_ROWS = gls_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gls_pkg::DEF_MAX_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // cell_row, cell_col, cell_kind, from_col, from_row, to_col, to_row, zero fill
    input  logic [gls_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // verdict, blocked_found, blocked_col, blocked_row, zero fill
    output logic [gls_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gls_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int RB = $clog2(MAX_ROWS);
    localparam int CB = $clog2(MAX_COLS);
    localparam int AW = RB + CB;

    logic [gls_pkg::CFG_W-1:0] r_rows, r_cols;
    logic                      r_clr_busy;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_ovalid;
    gls_pkg::t_result          r_ores;

    logic                       s_acc, start, wr_ok, mem_we, rd_en, idle;
    logic                       res_valid, res_ready;
    logic [5:0]                 cell_row, cell_col;
    logic [gls_pkg::KIND_W-1:0] cell_kind, mem_wdata, rd_data;
    logic [8:0]                 wr_row9, wr_col9, rows9, cols9;
    logic [AW-1:0]              mem_waddr, rd_addr;
    gls_pkg::t_query            query;
    gls_pkg::t_limits           lim;
    gls_pkg::t_result           res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gls_pkg::CFG_RESET;
            r_cols <= gls_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gls_pkg::CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_index == gls_pkg::CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    always_comb begin
        cell_row       = i_s_tdata[5:0];
        cell_col       = i_s_tdata[11:6];
        cell_kind      = i_s_tdata[13:12];
        query.from_col = i_s_tdata[21:14];
        query.from_row = i_s_tdata[29:22];
        query.to_col   = i_s_tdata[37:30];
        query.to_row   = i_s_tdata[45:38];

        rows9    = {2'b00, r_rows};
        cols9    = {2'b00, r_cols};
        lim.rows = (rows9 > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows9;
        lim.cols = (cols9 > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cols9;

        o_s_tready = !r_clr_busy && idle;
        s_acc      = i_s_tvalid && o_s_tready;
        start      = s_acc && (i_s_tuser == gls_pkg::CMD_QUERY);
        wr_row9    = {3'b000, cell_row};
        wr_col9    = {3'b000, cell_col};
        wr_ok      = s_acc && (i_s_tuser == gls_pkg::CMD_WRITE)
                     && (wr_row9 < 9'(MAX_ROWS)) && (wr_col9 < 9'(MAX_COLS));

        mem_we    = r_clr_busy || wr_ok;
        mem_waddr = r_clr_busy ? r_clr_addr : {wr_row9[RB-1:0], wr_col9[CB-1:0]};
        mem_wdata = r_clr_busy ? gls_pkg::KIND_EMPTY : cell_kind;

        res_ready = !r_ovalid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    gls_grid_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    gls_walker #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .AW      (AW)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_query     (query),
        .i_lim       (lim),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_ores <= res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'b00000, r_ores.blocked_row, r_ores.blocked_col,
                         r_ores.blocked_found, r_ores.verdict};

endmodule

>>> dv/grid_line_of_sight_walk_tb.sv
// Self-checking testbench for the grid line-of-sight walk: directed table, then random phases.
module grid_line_of_sight_walk_tb;

    localparam int COORD_W   = gls_pkg::COORD_W;
    localparam int CELL_W    = gls_pkg::CELL_W;
    localparam int KIND_W    = gls_pkg::KIND_W;
    localparam int CFG_W     = gls_pkg::CFG_W;
    localparam int CFG_IDX_W = gls_pkg::CFG_IDX_W;
    localparam int GRID_COLS = gls_pkg::DEF_MAX_COLS;
    localparam int GRID_ROWS = gls_pkg::DEF_MAX_ROWS;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int PLAN_LEN       = 21;
    localparam int PHASE_COUNT    = 7;

    localparam logic [KIND_W-1:0]    KIND_EXIT    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

    typedef struct packed {
        logic                      cmd;
        logic [CELL_W-1:0]         cell_row;
        logic [CELL_W-1:0]         cell_col;
        logic [KIND_W-1:0]         cell_kind;
        logic signed [COORD_W-1:0] from_col;
        logic signed [COORD_W-1:0] from_row;
        logic signed [COORD_W-1:0] to_col;
        logic signed [COORD_W-1:0] to_row;
        logic                      typed;
        gls_pkg::t_result          want;
    } t_probe;

    typedef struct packed {
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        int               items;
        int               tx_pct;
        int               rx_pct;
        bit               squeeze;
    } t_phase;

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_valid = 1'b0;
    logic [gls_pkg::IN_TDATA_W-1:0]  s_data = '0;
    logic                            s_user = 1'b0;
    logic                            m_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]            cfg_index = '0;
    logic [CFG_W-1:0]                cfg_data = '0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [gls_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_cfg_ready;

    logic [KIND_W-1:0] grid_kind [0:GRID_ROWS*GRID_COLS-1]
        = '{default: gls_pkg::KIND_EMPTY};
    logic [CFG_W-1:0]  lim_rows = gls_pkg::CFG_RESET;
    logic [CFG_W-1:0]  lim_cols = gls_pkg::CFG_RESET;
    gls_pkg::t_result  pending_sight [$];
    int                mismatches = 0;
    int                tx_idle_pct = 34;
    int                rx_idle_pct = 54;
    bit                rx_hold_req = 1'b0;
    bit                rx_hold_taken = 1'b0;
    int                rx_hold_left = 0;
    int                stall_cycles = 0;

    grid_line_of_sight_walk dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_probe wr(int r, int c, logic [KIND_W-1:0] k);
        t_probe p;
        p = '0;
        p.cmd = gls_pkg::CMD_WRITE;
        p.cell_row = r[CELL_W-1:0];
        p.cell_col = c[CELL_W-1:0];
        p.cell_kind = k;
        return p;
    endfunction

    function automatic t_probe qy(int fc, int fr, int tc, int tr);
        t_probe p;
        p = '0;
        p.cmd = gls_pkg::CMD_QUERY;
        p.from_col = fc[COORD_W-1:0];
        p.from_row = fr[COORD_W-1:0];
        p.to_col = tc[COORD_W-1:0];
        p.to_row = tr[COORD_W-1:0];
        return p;
    endfunction

    function automatic t_probe qx(int fc, int fr, int tc, int tr, logic f, logic [1:0] v,
                                  int bc, int br);
        t_probe p;
        p = qy(fc, fr, tc, tr);
        p.typed = 1'b1;
        p.want.blocked_found = f;
        p.want.verdict = v;
        p.want.blocked_col = bc[COORD_W-1:0];
        p.want.blocked_row = br[COORD_W-1:0];
        return p;
    endfunction

    t_probe sight_plan [0:PLAN_LEN-1] = '{
        qx(0, 0, 63, 63, 1'b0, gls_pkg::VERDICT_CLEAR, 63, 63),
        qx(-128, -128, 127, 127, 1'b0, gls_pkg::VERDICT_CLEAR, 127, 127),
        wr(0, 0, gls_pkg::KIND_SOLID),
        qx(0, 0, 0, 0, 1'b1, gls_pkg::VERDICT_SOLID, 0, 0),
        wr(63, 63, gls_pkg::KIND_DEST),
        qx(63, 63, 63, 63, 1'b1, gls_pkg::VERDICT_DEST, 63, 63),
        wr(5, 10, KIND_EXIT),
        qx(1, 5, 20, 5, 1'b0, gls_pkg::VERDICT_CLEAR, 20, 5),
        wr(5, 12, gls_pkg::KIND_DEST),
        wr(5, 15, gls_pkg::KIND_SOLID),
        qx(1, 5, 20, 5, 1'b1, gls_pkg::VERDICT_SOLID, 12, 5),
        qx(20, 5, 1, 5, 1'b1, gls_pkg::VERDICT_SOLID, 15, 5),
        wr(0, 0, gls_pkg::KIND_EMPTY),
        qy(-10, -10, 70, 70),
        qy(127, -128, -128, 127),
        wr(63, 0, KIND_EXIT),
        wr(0, 63, gls_pkg::KIND_SOLID),
        qx(0, 0, 63, 0, 1'b1, gls_pkg::VERDICT_SOLID, 63, 0),
        qy(-128, 127, 127, -128),
        qy(3, -2, 40, 25),
        qx(12, 0, 12, 10, 1'b1, gls_pkg::VERDICT_DEST, 12, 5)
    };

    t_phase phase_plan [0:PHASE_COUNT-1] = '{
        '{7'd0,   7'd64,  150, 34, 54, 1'b0},
        '{7'd127, 7'd127, 250, 34, 54, 1'b0},
        '{7'd1,   7'd1,   150, 34, 54, 1'b0},
        '{7'd20,  7'd33,  300, 54, 34, 1'b0},
        '{7'd64,  7'd0,   150, 54, 34, 1'b0},
        '{7'd64,  7'd64,  450, 0,  0,  1'b1},
        '{7'd9,   7'd64,  300, 0,  0,  1'b0}
    };

    function automatic gls_pkg::t_result trace_sight_line(int x0, int y0, int x1, int y1);
        gls_pkg::t_result  res;
        int                dx, dy, sx, sy, err, e2, rows, cols, steps;
        logic [KIND_W-1:0] k;
        rows = (lim_rows > GRID_ROWS) ? GRID_ROWS : int'(lim_rows);
        cols = (lim_cols > GRID_COLS) ? GRID_COLS : int'(lim_cols);
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        res.verdict = gls_pkg::VERDICT_CLEAR;
        res.blocked_found = 1'b0;
        res.blocked_col = x1[COORD_W-1:0];
        res.blocked_row = y1[COORD_W-1:0];
        for (steps = 0; steps < 1024; steps++) begin
            if (y0 >= 0 && y0 < rows && x0 >= 0 && x0 < cols) begin
                k = grid_kind[y0 * GRID_COLS + x0];
                if (k == gls_pkg::KIND_SOLID || k == gls_pkg::KIND_DEST) begin
                    if (!res.blocked_found) begin
                        res.blocked_found = 1'b1;
                        res.blocked_col = x0[COORD_W-1:0];
                        res.blocked_row = y0[COORD_W-1:0];
                    end
                    if (k == gls_pkg::KIND_SOLID) begin
                        res.verdict = gls_pkg::VERDICT_SOLID;
                        break;
                    end
                    res.verdict = gls_pkg::VERDICT_DEST;
                end
            end
            if (x0 == x1 && y0 == y1)
                break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x0 += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y0 += sy;
            end
        end
        return res;
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(99) < 85)
            return int'($urandom_range(24)) - 4;
        return int'($urandom_range(255)) - 128;
    endfunction

    function automatic int pick_cell();
        if ($urandom_range(99) < 75)
            return int'($urandom_range(15));
        return int'($urandom_range(63));
    endfunction

    function automatic void enqueue_sight(gls_pkg::t_result r);
        pending_sight.insert(pending_sight.size(), r);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_probe(t_probe p);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= p.cmd;
        s_data <= {2'b00, p.to_row, p.to_col, p.from_row, p.from_col,
                   p.cell_kind, p.cell_col, p.cell_row};
        do @(posedge i_clk); while (!o_s_tready);
        if (p.cmd == gls_pkg::CMD_WRITE)
            grid_kind[int'(p.cell_row) * GRID_COLS + int'(p.cell_col)] = p.cell_kind;
        else if (p.typed)
            enqueue_sight(p.want);
        else
            enqueue_sight(trace_sight_line(p.from_col, p.from_row, p.to_col, p.to_row));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gls_pkg::CFG_ROWS)
            lim_rows = val;
        else if (idx == gls_pkg::CFG_COLS)
            lim_cols = val;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_sight.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : clock_gen
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin : receiver
        if (rx_hold_req && !rx_hold_taken) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_taken = 1'b1;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        gls_pkg::t_result got, want;
        if (rst_n && o_m_tvalid && m_ready) begin
            got.verdict = o_m_tdata[1:0];
            got.blocked_found = o_m_tdata[2];
            got.blocked_col = o_m_tdata[10:3];
            got.blocked_row = o_m_tdata[18:11];
            if (pending_sight.size() == 0) begin
                flag_mismatch("result beat with no query pending", 1, 0);
            end else begin
                want = pending_sight.pop_front();
                if (got.verdict != want.verdict)
                    flag_mismatch("verdict", got.verdict, want.verdict);
                if (got.blocked_found != want.blocked_found)
                    flag_mismatch("blocked_found", got.blocked_found, want.blocked_found);
                if (got.blocked_col != want.blocked_col)
                    flag_mismatch("blocked_col", got.blocked_col, want.blocked_col);
                if (got.blocked_row != want.blocked_row)
                    flag_mismatch("blocked_row", got.blocked_row, want.blocked_row);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_line_of_sight_walk test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_probe p;
        int     ph, n;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        for (n = 0; n < PLAN_LEN; n++)
            send_probe(sight_plan[n]);
        settle_block();
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_reg(gls_pkg::CFG_ROWS, phase_plan[ph].rows_val);
            write_reg(gls_pkg::CFG_COLS, phase_plan[ph].cols_val);
            write_reg(REG_UNMAPPED, CFG_W'($urandom_range(127)));
            tx_idle_pct = phase_plan[ph].tx_pct;
            rx_idle_pct = phase_plan[ph].rx_pct;
            if (phase_plan[ph].squeeze)
                rx_hold_req = 1'b1;
            for (n = 0; n < phase_plan[ph].items; n++) begin
                p = '0;
                p.cmd = ($urandom_range(99) < 40) ? gls_pkg::CMD_WRITE : gls_pkg::CMD_QUERY;
                p.cell_row = CELL_W'(pick_cell());
                p.cell_col = CELL_W'(pick_cell());
                case ($urandom_range(99)) inside
                    [0:39]:  p.cell_kind = gls_pkg::KIND_EMPTY;
                    [40:54]: p.cell_kind = gls_pkg::KIND_SOLID;
                    [55:79]: p.cell_kind = gls_pkg::KIND_DEST;
                    default: p.cell_kind = KIND_EXIT;
                endcase
                p.from_col = COORD_W'(pick_coord());
                p.from_row = COORD_W'(pick_coord());
                p.to_col = COORD_W'(pick_coord());
                p.to_row = COORD_W'(pick_coord());
                send_probe(p);
            end
            settle_block();
        end
        if (pending_sight.size() != 0)
            flag_mismatch("queries left without a result", pending_sight.size(), 0);
        if (mismatches == 0)
            $display("grid_line_of_sight_walk test passed");
        else
            $display("grid_line_of_sight_walk test failed");
        $finish;
    end

endmodule
